@@ src/tprp_pkg.sv @@
// Package with the shared types, codes and constants of the path record and playback unit.
`timescale 1ns / 1ps
`default_nettype none
package tprp_pkg;

    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 32;
    localparam int PROD_BITS  = COORD_BITS + TIME_BITS;
    localparam int DIV_CNT_W  = $clog2(PROD_BITS);

    // Request modes.
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_QUERY = 2'd3
    } tprp_mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_NONE    = 2'd1,
        ST_STORED  = 2'd2,
        ST_DROPPED = 2'd3
    } tprp_status_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [COORD_BITS-1:0] pos_x_in;
        logic [COORD_BITS-1:0] pos_y_in;
        logic [TIME_BITS-1:0]  timestamp;
    } tprp_req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x_out;
        logic [COORD_BITS-1:0] pos_y_out;
        logic [1:0]            status;
    } tprp_rsp_t;

    // One stored path point.
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [TIME_BITS-1:0]  t;
    } tprp_entry_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LAST,
        S_CHECK,
        S_MOD,
        S_SCAN,
        S_MUL_X,
        S_GO_X,
        S_WAIT_X,
        S_MUL_Y,
        S_GO_Y,
        S_WAIT_Y,
        S_FINISH
    } tprp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         capture;
        logic         do_start;
        logic         do_add;
        logic         do_stop;
        logic         rd_last;
        logic         load_last;
        logic         mod_go;
        logic         mod_load;
        logic         scan_init;
        logic         scan_en;
        logic         mul_x;
        logic         mul_y;
        logic         div_go;
        logic         load_x;
        logic         load_y;
        logic         emit;
        logic         emit_pos;
        tprp_status_t emit_status;
    } tprp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        tprp_mode_t mode;
        logic       table_full;
        logic       query_ok;
        logic       last_zero;
        logic       need_wrap;
        logic       div_done;
        logic       scan_done;
        logic       found;
    } tprp_stat_t;

endpackage
`default_nettype wire

@@ src/tprp_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tprp_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [tprp_pkg::PROD_BITS-1:0] dividend,
    input  wire logic [tprp_pkg::TIME_BITS-1:0] divisor,
    output logic                               done,
    output logic [tprp_pkg::PROD_BITS-1:0]     quot,
    output logic [tprp_pkg::TIME_BITS-1:0]     rem
);
    import tprp_pkg::*;

    logic [PROD_BITS-1:0] quot_reg, quot_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS:0]   shifted;
    logic [TIME_BITS:0]   diff;

    // One shift, compare and subtract step.
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[PROD_BITS-1]};
        diff      = shifted - {1'b0, dvs_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(PROD_BITS - 1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next  = diff[TIME_BITS-1:0];
                quot_next = {quot_reg[PROD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[TIME_BITS-1:0];
                quot_next = {quot_reg[PROD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (go)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

@@ src/tprp_dpath.sv @@
// Datapath: point memory, recording state, segment scan, interpolation and result register.
`timescale 1ns / 1ps
`default_nettype none
module tprp_dpath #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tprp_pkg::tprp_req_t request,
    input  wire tprp_pkg::tprp_cmd_t cmd,
    output tprp_pkg::tprp_stat_t     stat,
    output tprp_pkg::tprp_rsp_t      result,
    output logic                     done
);
    import tprp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);

    // Point memory.
    tprp_entry_t mem [MAX_POINTS];
    tprp_entry_t rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    tprp_entry_t       wr_data;

    tprp_req_t           req_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                recording_reg;
    logic [TIME_BITS-1:0] record_start_reg;
    logic [TIME_BITS-1:0] playback_start_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic [TIME_BITS-1:0] tm_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                pend_reg;
    logic                have_prev_reg;
    tprp_entry_t         prev_reg;
    tprp_entry_t         m0_reg;
    tprp_entry_t         m1_reg;
    logic [TIME_BITS-1:0] part_reg;
    logic [TIME_BITS-1:0] whole_reg;
    logic                found_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic                neg_reg;
    logic [COORD_BITS-1:0] base_reg;
    logic [COORD_BITS-1:0] x_res_reg;
    logic [COORD_BITS-1:0] y_res_reg;
    tprp_rsp_t           result_reg;
    logic                done_reg;

    logic                table_full;
    logic                scan_rd;
    logic [COORD_BITS-1:0] lerp_a;
    logic [COORD_BITS-1:0] lerp_b;
    logic [COORD_BITS-1:0] lerp_diff;
    logic [COORD_BITS-1:0] lerp_val;
    logic [PROD_BITS-1:0]  div_dividend;
    logic [TIME_BITS-1:0]  div_divisor;
    logic [TIME_BITS-1:0]  tm_dec;
    logic                  div_done;
    logic [PROD_BITS-1:0]  div_quot;
    logic [TIME_BITS-1:0]  div_rem;

    assign table_full = (count_reg >= CNT_W'(MAX_POINTS));
    assign scan_rd    = cmd.scan_en && (idx_reg != count_reg);

    // Memory address and write selection.
    always_comb
    begin
        wr_en   = cmd.do_start || (cmd.do_add && !table_full);
        wr_addr = cmd.do_start ? '0 : count_reg[ADDR_W-1:0];
        wr_data.x = req_reg.pos_x_in;
        wr_data.y = req_reg.pos_y_in;
        wr_data.t = cmd.do_start ? '0 : (req_reg.timestamp - record_start_reg);
        if (cmd.rd_last)
        begin
            rd_addr = ADDR_W'(count_reg - 1'b1);
        end
        else
        begin
            rd_addr = idx_reg[ADDR_W-1:0];
        end
    end

    // Memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Recording state and sequencing flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg          <= '0;
            recording_reg      <= 1'b0;
            record_start_reg   <= '0;
            playback_start_reg <= '0;
            pend_reg           <= 1'b0;
            have_prev_reg      <= 1'b0;
            found_reg          <= 1'b0;
            idx_reg            <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.do_start)
            begin
                recording_reg    <= 1'b1;
                count_reg        <= CNT_W'(1);
                record_start_reg <= req_reg.timestamp;
            end
            if (cmd.do_add && !table_full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.do_stop)
            begin
                recording_reg      <= 1'b0;
                playback_start_reg <= req_reg.timestamp;
            end
            if (cmd.scan_init)
            begin
                idx_reg       <= '0;
                pend_reg      <= 1'b0;
                have_prev_reg <= 1'b0;
                found_reg     <= 1'b0;
            end
            else
            begin
                pend_reg <= scan_rd;
                if (scan_rd)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    have_prev_reg <= 1'b1;
                    if (have_prev_reg && (tm_reg >= prev_reg.t) && (tm_reg < rd_data_reg.t))
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign tm_dec = tm_reg - 1'b1;

    // Divider operands: wrap modulo for time or interpolation quotient.
    always_comb
    begin
        if (cmd.mod_go)
        begin
            div_dividend = {{COORD_BITS{1'b0}}, tm_dec};
            div_divisor  = last_reg;
        end
        else
        begin
            div_dividend = prod_reg;
            div_divisor  = whole_reg;
        end
    end

    tprp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.mod_go || cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Interpolation operands for the selected axis.
    always_comb
    begin
        lerp_a    = cmd.mul_y ? m0_reg.y : m0_reg.x;
        lerp_b    = cmd.mul_y ? m1_reg.y : m1_reg.x;
        lerp_diff = (lerp_b >= lerp_a) ? (lerp_b - lerp_a) : (lerp_a - lerp_b);
        if (neg_reg)
        begin
            lerp_val = base_reg - div_quot[COORD_BITS-1:0];
        end
        else
        begin
            lerp_val = base_reg + div_quot[COORD_BITS-1:0];
        end
    end

    // Query payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.load_last)
        begin
            last_reg <= rd_data_reg.t;
            tm_reg   <= req_reg.timestamp - playback_start_reg;
        end
        if (cmd.mod_load)
        begin
            tm_reg <= div_rem + 1'b1;
        end
        if (pend_reg && !cmd.scan_init)
        begin
            prev_reg <= rd_data_reg;
            if (have_prev_reg && (tm_reg >= prev_reg.t) && (tm_reg < rd_data_reg.t))
            begin
                m0_reg    <= prev_reg;
                m1_reg    <= rd_data_reg;
                part_reg  <= tm_reg - prev_reg.t;
                whole_reg <= rd_data_reg.t - prev_reg.t;
            end
        end
        if (cmd.mul_x || cmd.mul_y)
        begin
            prod_reg <= PROD_BITS'(lerp_diff) * PROD_BITS'(part_reg);
            neg_reg  <= (lerp_b < lerp_a);
            base_reg <= lerp_a;
        end
        if (cmd.load_x)
        begin
            x_res_reg <= lerp_val;
        end
        if (cmd.load_y)
        begin
            y_res_reg <= lerp_val;
        end
        if (cmd.emit)
        begin
            result_reg.pos_x_out <= cmd.emit_pos ? x_res_reg : '0;
            result_reg.pos_y_out <= cmd.emit_pos ? y_res_reg : '0;
            result_reg.status    <= cmd.emit_status;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.mode       = tprp_mode_t'(req_reg.mode);
        stat.table_full = table_full;
        stat.query_ok   = !recording_reg && (count_reg >= CNT_W'(2));
        stat.last_zero  = (last_reg == '0);
        stat.need_wrap  = (tm_reg > last_reg);
        stat.div_done   = div_done;
        stat.scan_done  = (idx_reg == count_reg) && !pend_reg;
        stat.found      = found_reg;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

@@ src/tprp_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module tprp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire tprp_pkg::tprp_stat_t stat,
    output tprp_pkg::tprp_cmd_t       cmd,
    output logic                      busy
);
    import tprp_pkg::*;

    tprp_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = ST_NONE;
        busy            = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_START:
                    begin
                        cmd.do_start    = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_STORED;
                        state_next      = S_IDLE;
                    end
                    MODE_ADD:
                    begin
                        cmd.do_add      = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = stat.table_full ? ST_DROPPED : ST_STORED;
                        state_next      = S_IDLE;
                    end
                    MODE_STOP:
                    begin
                        cmd.do_stop = 1'b1;
                        cmd.emit    = 1'b1;
                        state_next  = S_IDLE;
                    end
                    default:
                    begin
                        if (stat.query_ok)
                        begin
                            cmd.rd_last = 1'b1;
                            state_next  = S_LAST;
                        end
                        else
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_LAST:
            begin
                cmd.load_last = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.last_zero)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.need_wrap)
                begin
                    cmd.mod_go = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_MOD:
            begin
                if (stat.div_done)
                begin
                    cmd.mod_load  = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        state_next = S_MUL_X;
                    end
                    else
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_GO_X;
            end
            S_GO_X:
            begin
                cmd.div_go = 1'b1;
                state_next = S_WAIT_X;
            end
            S_WAIT_X:
            begin
                if (stat.div_done)
                begin
                    cmd.load_x = 1'b1;
                    state_next = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_GO_Y;
            end
            S_GO_Y:
            begin
                cmd.div_go = 1'b1;
                state_next = S_WAIT_Y;
            end
            S_WAIT_Y:
            begin
                if (stat.div_done)
                begin
                    cmd.load_y = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_pos    = 1'b1;
                cmd.emit_status = ST_VALID;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/timed_path_record_playback_unit.sv @@
// Top level of the timed path record and playback unit.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; its single result appears on
// result for one cycle with done high, and the receiver cannot stall it. Start, add and
// stop requests are captured into a register, decoded, and give a registered result. A
// query takes longer: the path memory has one read port and the segment scan reads one
// point per cycle, and a shared divider that makes one quotient bit per cycle serves the
// time wrap and the x and y interpolation. Queries that find no position return sooner.
module timed_path_record_playback_unit #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire tprp_pkg::tprp_req_t request,
    output logic                     busy,
    output logic                     done,
    output tprp_pkg::tprp_rsp_t      result
);
    import tprp_pkg::*;

    tprp_cmd_t  cmd;
    tprp_stat_t stat;

    tprp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tprp_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .done    (done)
    );

    // A result only follows a request that was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a request");

    // Any result other than a valid position carries zero coordinates.
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_VALID)) |->
            ((result.pos_x_out == '0) && (result.pos_y_out == '0)))
        else $error("nonzero position without valid status");

endmodule
`default_nettype wire
